// ===== sv/rtm_pkg.sv =====
// rtm_pkg: shared constants, lane types and output saturation for the
// Reinhard tone map pixel pipeline. No dependencies.

package rtm_pkg;

    // Field widths
    localparam int IN_W          = 32;
    localparam int OUT_W         = 16;
    localparam int KEY_W         = 32;
    localparam int NUM_CH        = 3;

    // Fraction bits of the mapped value; one divider cell per bit
    localparam int OUT_FRAC_BITS = 16;
    localparam int Q_W           = OUT_FRAC_BITS;

    // 0.18 scale as 11796 / 2^16
    localparam int SCALE_W       = 14;
    localparam int SCALE_SHIFT   = 16;
    localparam logic [SCALE_W-1:0] SCALE_NUM = SCALE_W'(11796);

    // Scaled value and divisor widths
    localparam int A_W  = IN_W + SCALE_W - SCALE_SHIFT;
    localparam int D_W  = ((KEY_W > A_W) ? KEY_W : A_W) + 1;
    localparam int P_W  = IN_W + SCALE_W;

    localparam logic [KEY_W-1:0] KEY_RESET = KEY_W'(11796);
    localparam logic [OUT_W-1:0] OUT_MAX   = '1;

    typedef logic [NUM_CH-1:0][IN_W-1:0]  t_pix_in;
    typedef logic [NUM_CH-1:0][OUT_W-1:0] t_pix_out;
    typedef logic [NUM_CH-1:0][A_W-1:0]   t_scaled;

    // One color channel moving down the divider chain
    typedef struct packed {
        logic [D_W-1:0] rem;   // partial remainder, below dvs while key is nonzero
        logic [D_W-1:0] dvs;   // key + a
        logic [Q_W-1:0] quo;   // quotient bits so far
        logic           zero;  // scaled value was zero
    } t_lane;

    typedef t_lane [NUM_CH-1:0] t_lanes;

    // Final quotient to the output field; zero input forces zero,
    // a quotient above the field saturates
    function automatic logic [OUT_W-1:0] sat_out(input logic [Q_W-1:0] q,
                                                 input logic           zero);
        logic [Q_W+OUT_W-1:0] ext;
        logic [OUT_W-1:0]     res;
        ext = (Q_W+OUT_W)'(q);
        if (zero) begin
            res = '0;
        end else if (ext > (Q_W+OUT_W)'(OUT_MAX)) begin
            res = OUT_MAX;
        end else begin
            res = ext[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/rtm_scale.sv =====
// rtm_scale: two-stage front end. Stage one scales each channel by 0.18,
// stage two forms the divisor key + a and seeds the divider lanes.
// Depends on rtm_pkg.

module rtm_scale (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  rtm_pkg::t_pix_in       i_pix,
    input  logic [rtm_pkg::KEY_W-1:0] i_key,
    output logic                   o_valid,
    input  logic                   i_ready,
    output rtm_pkg::t_lanes        o_lanes
);

    logic                 r_s1_valid, n_s1_valid;
    rtm_pkg::t_scaled     r_s1_a, n_s1_a;
    logic                 r_s2_valid, n_s2_valid;
    rtm_pkg::t_lanes      r_s2_lanes, n_s2_lanes;
    logic                 w_s1_ready, w_s2_ready;
    logic [rtm_pkg::P_W-1:0] w_prod [rtm_pkg::NUM_CH];

    // Stage readiness: a stage takes data when empty or draining
    assign w_s2_ready = !r_s2_valid || i_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_ready    = w_s1_ready;

    // Stage one: multiply by the 0.18 constant and drop 16 fraction bits
    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_a     = r_s1_a;
        for (int c = 0; c < rtm_pkg::NUM_CH; c++) begin
            w_prod[c] = rtm_pkg::P_W'(i_pix[c]) * rtm_pkg::P_W'(rtm_pkg::SCALE_NUM);
        end
        if (w_s1_ready) begin
            n_s1_valid = i_valid;
            for (int c = 0; c < rtm_pkg::NUM_CH; c++) begin
                n_s1_a[c] = w_prod[c][rtm_pkg::P_W-1:rtm_pkg::SCALE_SHIFT];
            end
        end
    end

    // Stage two: divisor and initial remainder
    always_comb begin
        n_s2_valid = r_s2_valid;
        n_s2_lanes = r_s2_lanes;
        if (w_s2_ready) begin
            n_s2_valid = r_s1_valid;
            for (int c = 0; c < rtm_pkg::NUM_CH; c++) begin
                n_s2_lanes[c].dvs  = rtm_pkg::D_W'(i_key) + rtm_pkg::D_W'(r_s1_a[c]);
                n_s2_lanes[c].rem  = rtm_pkg::D_W'(r_s1_a[c]);
                n_s2_lanes[c].quo  = '0;
                n_s2_lanes[c].zero = (r_s1_a[c] == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a     <= n_s1_a;
        r_s2_lanes <= n_s2_lanes;
    end

    assign o_valid = r_s2_valid;
    assign o_lanes = r_s2_lanes;

endmodule

// ===== sv/rtm_div_cell.sv =====
// rtm_div_cell: one restoring-division step for all three channels, with
// its own pipeline register and valid/ready. Depends on rtm_pkg.

module rtm_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rtm_pkg::t_lanes  i_lanes,
    output logic             o_valid,
    input  logic             i_ready,
    output rtm_pkg::t_lanes  o_lanes
);

    logic                      r_valid, n_valid;
    rtm_pkg::t_lanes           r_lanes, n_lanes;
    rtm_pkg::t_lanes           w_step;
    logic [rtm_pkg::D_W:0]     w_dbl  [rtm_pkg::NUM_CH];
    logic [rtm_pkg::D_W:0]     w_diff [rtm_pkg::NUM_CH];

    assign o_ready = !r_valid || i_ready;

    // Shift remainder left (zero bit in), subtract divisor if it fits
    always_comb begin
        w_step = i_lanes;
        for (int c = 0; c < rtm_pkg::NUM_CH; c++) begin
            w_dbl[c]  = {i_lanes[c].rem, 1'b0};
            w_diff[c] = w_dbl[c] - {1'b0, i_lanes[c].dvs};
            if (!w_diff[c][rtm_pkg::D_W]) begin
                w_step[c].rem = w_diff[c][rtm_pkg::D_W-1:0];
                w_step[c].quo = {i_lanes[c].quo[rtm_pkg::Q_W-2:0], 1'b1};
            end else begin
                w_step[c].rem = w_dbl[c][rtm_pkg::D_W-1:0];
                w_step[c].quo = {i_lanes[c].quo[rtm_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_lanes = r_lanes;
        if (o_ready) begin
            n_valid = i_valid;
            n_lanes = w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

// ===== sv/reinhard_tone_map_pixel.sv =====
// reinhard_tone_map_pixel: top level. Key register, scale front end and a
// chain of restoring-division cells. Depends on rtm_pkg, rtm_scale,
// rtm_div_cell.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_red_in, i_green_in, i_blue_in
//  out       output     o_out_valid / i_out_ready  o_red_out, o_green_out, o_blue_out
//  key       input      i_key_we (no wait)         i_key_value
//
// One pixel per clock sustained while the output is ready; the pipeline is
// one multiply stage, one divisor stage, then one cell per quotient bit.
// Reset (synchronous, active low) empties the pipeline and sets the key
// to 11796 (about 0.18). Each stage holds when full and the next stage
// is stalled, so empty stages keep taking pixels while the output waits.

module reinhard_tone_map_pixel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rtm_pkg::IN_W-1:0]    i_red_in,
    input  logic [rtm_pkg::IN_W-1:0]    i_green_in,
    input  logic [rtm_pkg::IN_W-1:0]    i_blue_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rtm_pkg::OUT_W-1:0]   o_red_out,
    output logic [rtm_pkg::OUT_W-1:0]   o_green_out,
    output logic [rtm_pkg::OUT_W-1:0]   o_blue_out,
    input  logic                        i_key_we,
    input  logic [rtm_pkg::KEY_W-1:0]   i_key_value
);

    localparam int NCELL = rtm_pkg::Q_W;

    logic [rtm_pkg::KEY_W-1:0] r_key;
    rtm_pkg::t_pix_in          w_pix;
    logic                      w_valid [NCELL+1];
    logic                      w_ready [NCELL+1];
    rtm_pkg::t_lanes           w_lanes [NCELL+1];

    // Scene key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= rtm_pkg::KEY_RESET;
        end else if (i_key_we) begin
            r_key <= i_key_value;
        end
    end

    assign w_pix[0] = i_red_in;
    assign w_pix[1] = i_green_in;
    assign w_pix[2] = i_blue_in;

    rtm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_pix   (w_pix),
        .i_key   (r_key),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_lanes (w_lanes[0])
    );

    // Divider chain: one quotient bit per cell
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rtm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_lanes (w_lanes[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_lanes (w_lanes[k+1])
        );
    end

    assign w_ready[NCELL] = i_out_ready;
    assign o_out_valid    = w_valid[NCELL];

    // Zero forcing and saturation to the output field
    assign o_red_out   = rtm_pkg::sat_out(w_lanes[NCELL][0].quo, w_lanes[NCELL][0].zero);
    assign o_green_out = rtm_pkg::sat_out(w_lanes[NCELL][1].quo, w_lanes[NCELL][1].zero);
    assign o_blue_out  = rtm_pkg::sat_out(w_lanes[NCELL][2].quo, w_lanes[NCELL][2].zero);

endmodule
